>>> rtl/sweep_prune_pair_finder_macros.svh
// Assertion macros shared by the sweep-and-prune pair finder RTL.
`ifndef SWEEP_PRUNE_PAIR_FINDER_MACROS_SVH
`define SWEEP_PRUNE_PAIR_FINDER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define SPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define SPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spp_pkg.sv
// Shared types and constants of the sweep-and-prune pair finder.
package spp_pkg;

    localparam int COORD_BITS      = 24;
    localparam int BODY_ID_BITS    = 6;
    localparam int MAX_BODIES_DEF  = 64;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_FETCH = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_PAIR = 2'd1,
        ST_NONE = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [1:0]                   opcode;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [COORD_BITS-1:0] radius;
        logic                         is_static;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [BODY_ID_BITS-1:0] first_body;
        logic [BODY_ID_BITS-1:0] second_body;
    } rsp_t;

    // One stored box: centre, clamped radius, lower X edge and static flag.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [COORD_BITS-2:0]        r;
        logic signed [COORD_BITS:0]   lowx;
        logic                         stat;
    } body_t;

    typedef struct packed {
        logic rotate;
        logic insert;
        logic clear;
    } ring_ctrl_t;

endpackage

>>> rtl/spp_cell.sv
// One slot of the sorted body ring: sorted insert, rotate and clear.
module spp_cell #(
    parameter int IDXW = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spp_pkg::ring_ctrl_t ctrl,
    input  spp_pkg::body_t     new_body,
    input  logic [IDXW-1:0]    new_idx,
    input  logic               prev_keep,
    input  spp_pkg::body_t     prev_body,
    input  logic [IDXW-1:0]    prev_idx,
    input  logic               prev_valid,
    input  spp_pkg::body_t     next_body,
    input  logic [IDXW-1:0]    next_idx,
    input  logic               next_valid,
    output spp_pkg::body_t     body,
    output logic [IDXW-1:0]    idx,
    output logic               valid,
    output logic               keep
);
    import spp_pkg::*;

    body_t           body_reg;
    logic [IDXW-1:0] idx_reg;
    logic            valid_reg;

    // Hold the slot when its key does not exceed the new key (stable order).
    assign keep  = valid_reg && (body_reg.lowx <= new_body.lowx);
    assign body  = body_reg;
    assign idx   = idx_reg;
    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (!keep)
            begin
                valid_reg <= prev_keep ? 1'b1 : prev_valid;
            end
        end
        else if (ctrl.rotate)
        begin
            valid_reg <= next_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert && !keep)
        begin
            body_reg <= prev_keep ? new_body : prev_body;
            idx_reg  <= prev_keep ? new_idx : prev_idx;
        end
        else if (ctrl.rotate && !ctrl.insert && !ctrl.clear)
        begin
            body_reg <= next_body;
            idx_reg  <= next_idx;
        end
    end

endmodule

>>> rtl/spp_ring.sv
// Ring of body cells kept in sweep order; slot zero is the read head.
module spp_ring #(
    parameter int MAX_BODIES = spp_pkg::MAX_BODIES_DEF,
    parameter int IDXW       = $clog2(MAX_BODIES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spp_pkg::ring_ctrl_t ctrl,
    input  spp_pkg::body_t      new_body,
    input  logic [IDXW-1:0]     new_idx,
    output spp_pkg::body_t      head_body,
    output logic [IDXW-1:0]     head_idx
);
    import spp_pkg::*;

    body_t           body_w  [MAX_BODIES];
    logic [IDXW-1:0] idx_w   [MAX_BODIES];
    logic            valid_w [MAX_BODIES];
    logic            keep_w  [MAX_BODIES];

    for (genvar k = 0; k < MAX_BODIES; k++)
    begin : g_cell
        localparam int PREV = (k == 0) ? 0 : k - 1;
        localparam int NEXT = (k == MAX_BODIES - 1) ? 0 : k + 1;

        spp_cell #(.IDXW(IDXW)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_body   (new_body),
            .new_idx    (new_idx),
            .prev_keep  ((k == 0) ? 1'b1 : keep_w[PREV]),
            .prev_body  (body_w[PREV]),
            .prev_idx   (idx_w[PREV]),
            .prev_valid (valid_w[PREV]),
            .next_body  (body_w[NEXT]),
            .next_idx   (idx_w[NEXT]),
            .next_valid (valid_w[NEXT]),
            .body       (body_w[k]),
            .idx        (idx_w[k]),
            .valid      (valid_w[k]),
            .keep       (keep_w[k])
        );
    end

    assign head_body = body_w[0];
    assign head_idx  = idx_w[0];

endmodule

>>> rtl/sweep_prune_pair_finder.sv
// Sweep-and-prune pair finder: top level with the sweep sequencer.
// Clear, no-op and full-store load respond at the accepting edge; a load first turns the ring
// back to slot zero, then inserts; a fetch rotates the ring to each sweep position in turn
// and tries the earlier candidates against it until it finds a pair or runs out.
// Only one request is in the sequencer at a time; a finished response parks in a holding register.
// Reset clears state, body count, cursors, ring valid bits and both response valid flags.
`include "sweep_prune_pair_finder_macros.svh"

module sweep_prune_pair_finder #(
    parameter int MAX_BODIES = spp_pkg::MAX_BODIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spp_pkg::rsp_t rsp
);
    import spp_pkg::*;

    localparam int IDXW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW   = $clog2(MAX_BODIES + 1);
    localparam int CB   = COORD_BITS;

    // Sequencer and sweep state.
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg;
    logic            sorted_reg;
    logic [CW-1:0]   sw_reg;       // sweep cursor: position of the current body
    logic [CW-1:0]   cd_reg;       // candidate cursor: earlier body to try next
    logic            cur_valid_reg;
    body_t           cur_reg;
    logic [IDXW-1:0] cur_idx_reg;
    logic [IDXW-1:0] head_pos_reg; // sweep position sitting in ring slot zero
    req_t            req_reg;
    logic            rsp_valid_reg;
    rsp_t            rsp_reg;
    logic            hold_valid_reg; // finished response waiting behind rsp_reg
    rsp_t            hold_reg;

    // Ring interface.
    ring_ctrl_t      ring_ctrl;
    body_t           new_body;
    body_t           head_body;
    logic [IDXW-1:0] head_idx;

    // Control decoded in the output block.
    logic            rsp_load;
    rsp_t            rsp_new;
    logic            latch_cur;
    logic            advance_sw;
    logic            step_cd;

    logic            req_fire;
    logic            rsp_free;
    logic            full;
    logic            sw_in_range;
    logic            at_sw;
    logic            at_cd;
    logic            cd_left;
    logic            hit;

    logic [CB-2:0]   r_clamp;
    logic signed [CB:0] hx_head, ly_head, hy_head, lz_head, hz_head;
    logic signed [CB:0] ly_cur, hy_cur, lz_cur, hz_cur;

    assign req_fire  = req_valid && req_ready;
    // Take a new request while the previous response still waits, as long as
    // the holding register is free to catch the next one.
    assign req_ready = (state_reg == S_IDLE) && !hold_valid_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full        = (count_reg == CW'(MAX_BODIES));
    assign sw_in_range = (sw_reg < count_reg);
    assign at_sw       = (head_pos_reg == sw_reg[IDXW-1:0]);
    assign at_cd       = (head_pos_reg == cd_reg[IDXW-1:0]);
    assign cd_left     = (cd_reg < sw_reg);

    // Build the box of the latched load request; clamp a negative radius.
    assign r_clamp = req_reg.radius[CB-1] ? '0 : req_reg.radius[CB-2:0];
    always_comb
    begin
        new_body.x    = req_reg.pos_x;
        new_body.y    = req_reg.pos_y;
        new_body.z    = req_reg.pos_z;
        new_body.r    = r_clamp;
        new_body.lowx = $signed({req_reg.pos_x[CB-1], req_reg.pos_x})
                      - $signed({2'b00, r_clamp});
        new_body.stat = req_reg.is_static;
    end

    // Overlap test of the ring head (candidate) against the current body.
    // Edges are one bit wider than the centres, so nothing wraps.
    assign hx_head = $signed({head_body.x[CB-1], head_body.x}) + $signed({2'b00, head_body.r});
    assign ly_head = $signed({head_body.y[CB-1], head_body.y}) - $signed({2'b00, head_body.r});
    assign hy_head = $signed({head_body.y[CB-1], head_body.y}) + $signed({2'b00, head_body.r});
    assign lz_head = $signed({head_body.z[CB-1], head_body.z}) - $signed({2'b00, head_body.r});
    assign hz_head = $signed({head_body.z[CB-1], head_body.z}) + $signed({2'b00, head_body.r});
    assign ly_cur  = $signed({cur_reg.y[CB-1], cur_reg.y}) - $signed({2'b00, cur_reg.r});
    assign hy_cur  = $signed({cur_reg.y[CB-1], cur_reg.y}) + $signed({2'b00, cur_reg.r});
    assign lz_cur  = $signed({cur_reg.z[CB-1], cur_reg.z}) - $signed({2'b00, cur_reg.r});
    assign hz_cur  = $signed({cur_reg.z[CB-1], cur_reg.z}) + $signed({2'b00, cur_reg.r});

    assign hit = (hx_head >= cur_reg.lowx)
              && (ly_head <= hy_cur) && (hy_head >= ly_cur)
              && (lz_head <= hz_cur) && (hz_head >= lz_cur)
              && !(head_body.stat && cur_reg.stat);

    spp_ring #(.MAX_BODIES(MAX_BODIES), .IDXW(IDXW)) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ring_ctrl),
        .new_body  (new_body),
        .new_idx   (count_reg[IDXW-1:0]),
        .head_body (head_body),
        .head_idx  (head_idx)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.opcode == OP_LOAD && !full)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (req.opcode == OP_FETCH)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_LOAD:
            begin
                if (head_pos_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!sw_in_range)
                begin
                    state_next = S_IDLE;
                end
                else if (cur_valid_reg && cd_left && at_cd && hit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: ring commands, cursor moves, response.
    always_comb
    begin
        ring_ctrl   = '0;
        rsp_load    = 1'b0;
        rsp_new     = '0;
        latch_cur   = 1'b0;
        advance_sw  = 1'b0;
        step_cd     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.opcode)
                        OP_LOAD:
                        begin
                            if (full)
                            begin
                                rsp_load       = 1'b1;
                                rsp_new.status = ST_FULL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            ring_ctrl.clear = 1'b1;
                            rsp_load        = 1'b1;
                            rsp_new.status  = ST_DONE;
                        end
                        OP_NOP:
                        begin
                            rsp_load       = 1'b1;
                            rsp_new.status = ST_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                // Turn the ring back to sweep position zero, then insert.
                if (head_pos_reg == '0)
                begin
                    ring_ctrl.insert = 1'b1;
                    rsp_load         = 1'b1;
                    rsp_new.status   = ST_DONE;
                end
                else
                begin
                    ring_ctrl.rotate = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (!sw_in_range)
                begin
                    rsp_load       = 1'b1;
                    rsp_new.status = ST_NONE;
                end
                else if (!cur_valid_reg)
                begin
                    if (at_sw)
                    begin
                        latch_cur = 1'b1;
                    end
                    else
                    begin
                        ring_ctrl.rotate = 1'b1;
                    end
                end
                else if (!cd_left)
                begin
                    advance_sw = 1'b1;
                end
                else if (!at_cd)
                begin
                    ring_ctrl.rotate = 1'b1;
                end
                else
                begin
                    step_cd = 1'b1;
                    if (hit)
                    begin
                        rsp_load            = 1'b1;
                        rsp_new.status      = ST_PAIR;
                        rsp_new.first_body  = BODY_ID_BITS'(head_idx);
                        rsp_new.second_body = BODY_ID_BITS'(cur_idx_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            sorted_reg     <= 1'b0;
            sw_reg         <= '0;
            cd_reg         <= '0;
            cur_valid_reg  <= 1'b0;
            head_pos_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Drop the sweep on any load or clear; restart it on the next fetch.
            if (req_fire)
            begin
                if (req.opcode == OP_LOAD)
                begin
                    sorted_reg <= 1'b0;
                end
                else if (req.opcode == OP_CLEAR)
                begin
                    sorted_reg    <= 1'b0;
                    count_reg     <= '0;
                    sw_reg        <= '0;
                    cd_reg        <= '0;
                    cur_valid_reg <= 1'b0;
                    head_pos_reg  <= '0;
                end
                else if (req.opcode == OP_FETCH && !sorted_reg)
                begin
                    sorted_reg    <= 1'b1;
                    sw_reg        <= '0;
                    cd_reg        <= '0;
                    cur_valid_reg <= 1'b0;
                end
            end

            if (ring_ctrl.insert)
            begin
                count_reg <= count_reg + CW'(1);
            end

            if (ring_ctrl.rotate)
            begin
                if (head_pos_reg == IDXW'(MAX_BODIES - 1))
                begin
                    head_pos_reg <= '0;
                end
                else
                begin
                    head_pos_reg <= head_pos_reg + IDXW'(1);
                end
            end

            if (latch_cur)
            begin
                cur_valid_reg <= 1'b1;
            end
            if (advance_sw)
            begin
                sw_reg        <= sw_reg + CW'(1);
                cd_reg        <= '0;
                cur_valid_reg <= 1'b0;
            end
            if (step_cd)
            begin
                cd_reg <= cd_reg + CW'(1);
            end

            // Send a new response straight out when the output is free, else
            // park it; advance a parked response once the output frees up.
            if (rsp_load)
            begin
                if (rsp_free)
                begin
                    rsp_valid_reg <= 1'b1;
                end
                else
                begin
                    hold_valid_reg <= 1'b1;
                end
            end
            else if (hold_valid_reg && rsp_free)
            begin
                rsp_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        if (latch_cur)
        begin
            cur_reg     <= head_body;
            cur_idx_reg <= head_idx;
        end
        if (rsp_load && rsp_free)
        begin
            rsp_reg <= rsp_new;
        end
        else if (hold_valid_reg && rsp_free)
        begin
            rsp_reg <= hold_reg;
        end
        if (rsp_load && !rsp_free)
        begin
            hold_reg <= rsp_new;
        end
    end

    `SPP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_BODIES), "body count over capacity")
    `SPP_ASSERT_NOW(a_cursor_order, clk, rst_n, state_reg == S_SCAN && cur_valid_reg, cd_reg <= sw_reg, "candidate cursor passed sweep cursor")
    `SPP_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped or changed while waiting")
    `SPP_ASSERT_NOW(a_load_room, clk, rst_n, ring_ctrl.insert, !full, "insert into a full ring")
    `SPP_ASSERT_NOW(a_hold_order, clk, rst_n, hold_valid_reg, rsp_valid_reg, "parked response with none in front")

endmodule

>>> sim/spp_pair_checker.sv
// Checker for the sweep-and-prune pair finder: watches both channels, predicts and compares.
module spp_pair_checker #(
    parameter int MAX_BODIES = spp_pkg::MAX_BODIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  spp_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  spp_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending,
    output int            pair_count,
    output int            full_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import spp_pkg::*;

    typedef logic signed [COORD_BITS:0] edge_t;

    edge_t cen_x [MAX_BODIES];
    edge_t cen_y [MAX_BODIES];
    edge_t cen_z [MAX_BODIES];
    edge_t rad   [MAX_BODIES];
    bit    still [MAX_BODIES];
    int    sweep_order [MAX_BODIES];
    int    n_bodies;
    bit    order_valid;
    int    sweep_pos;
    int    cand_pos;

    rsp_t  expected_rsps[$];

    function automatic edge_t lower_x(int b);
        return cen_x[b] - rad[b];
    endfunction

    function automatic bit boxes_touch(int a, int b);
        return (cen_x[a] + rad[a] >= cen_x[b] - rad[b]) &&
               (cen_y[a] - rad[a] <= cen_y[b] + rad[b]) &&
               (cen_y[a] + rad[a] >= cen_y[b] - rad[b]) &&
               (cen_z[a] - rad[a] <= cen_z[b] + rad[b]) &&
               (cen_z[a] + rad[a] >= cen_z[b] - rad[b]);
    endfunction

    // Stable insertion sort on lower X edge; load index breaks ties.
    task automatic sort_bodies();
        int    k;
        edge_t key;
        for (int i = 0; i < n_bodies; i++)
        begin
            key = lower_x(i);
            k = i;
            while (k > 0 && lower_x(sweep_order[k-1]) > key)
            begin
                sweep_order[k] = sweep_order[k-1];
                k--;
            end
            sweep_order[k] = i;
        end
        order_valid = 1'b1;
        sweep_pos = 0;
        cand_pos = 0;
    endtask

    task automatic predict_pair(input req_t q, output rsp_t r);
        int cur;
        int cand;
        r = '0;
        r.status = ST_DONE;
        case (q.opcode)
            OP_LOAD:
            begin
                order_valid = 1'b0;
                if (n_bodies >= MAX_BODIES)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    cen_x[n_bodies] = edge_t'(q.pos_x);
                    cen_y[n_bodies] = edge_t'(q.pos_y);
                    cen_z[n_bodies] = edge_t'(q.pos_z);
                    rad[n_bodies]   = q.radius < 0 ? edge_t'(0) : edge_t'(q.radius);
                    still[n_bodies] = q.is_static;
                    n_bodies++;
                end
            end
            OP_CLEAR:
            begin
                n_bodies = 0;
                order_valid = 1'b0;
                sweep_pos = 0;
                cand_pos = 0;
            end
            OP_FETCH:
            begin
                if (!order_valid)
                    sort_bodies();
                r.status = ST_NONE;
                while (sweep_pos < n_bodies && r.status == ST_NONE)
                begin
                    cur = sweep_order[sweep_pos];
                    while (cand_pos < sweep_pos && r.status == ST_NONE)
                    begin
                        cand = sweep_order[cand_pos];
                        cand_pos++;
                        if (boxes_touch(cand, cur) && !(still[cand] && still[cur]))
                        begin
                            r.status = ST_PAIR;
                            r.first_body = BODY_ID_BITS'(cand);
                            r.second_body = BODY_ID_BITS'(cur);
                        end
                    end
                    if (r.status == ST_NONE)
                    begin
                        sweep_pos++;
                        cand_pos = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pair_count = 0;
        full_count = 0;
        n_bodies = 0;
        order_valid = 1'b0;
        sweep_pos = 0;
        cand_pos = 0;
    end

    assign pending = expected_rsps.size();

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            // Queue before pop: a response in the same cycle belongs to an older request.
            if (req_valid && req_ready)
            begin
                predict_pair(req, want);
                expected_rsps = {expected_rsps, want};
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("unexpected response, status", rsp.status, -1);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status != want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.first_body != want.first_body)
                        report_mismatch("first_body", rsp.first_body, want.first_body);
                    if (rsp.second_body != want.second_body)
                        report_mismatch("second_body", rsp.second_body, want.second_body);
                    if (want.status == ST_PAIR)
                        pair_count++;
                    if (want.status == ST_FULL)
                        full_count++;
                end
            end
        end
    end

endmodule

>>> sim/tb_sweep_prune_pair_finder.sv
// Top of the sweep-and-prune pair finder testbench: clock, reset, request stimulus, verdict.
module tb_sweep_prune_pair_finder;
    timeunit 1ns;
    timeprecision 1ps;
    import spp_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int IDLE_LIMIT  = 60000;
    localparam int DRAIN_WAIT  = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int  fail_count;
    int  pending;
    int  pair_count;
    int  full_count;
    int  sent = 0;
    int  idle_cycles = 0;
    int  rsp_hold = 0;
    bit  stall_on = 1'b1;

    always #2 clk = ~clk;

    sweep_prune_pair_finder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    spp_pair_checker CHECK (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .pair_count (pair_count),
        .full_count (full_count)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Stall the response side at the falling edge; hold ready low for the whole gap.
    always @(negedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_ready <= 1'b0;
            rsp_hold--;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (stall_on && $urandom_range(0, 3) == 0)
                rsp_hold = pick_gap();
        end
    end

    // Watchdog: stop the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d responses pending",
                     IDLE_LIMIT, pending);
            $display("sweep_prune_pair_finder: mismatch");
            $finish;
        end
    end

    // Present one request at the falling edge and hold it until accepted.
    // Valid stays high into the next request unless a gap drops it.
    task automatic send_request(input req_t q);
        int gap;
        gap = stall_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= q;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_op(input opcode_t op);
        req_t q;
        q = '0;
        q.opcode = op;
        q.pos_x = COORD_BITS'($urandom);
        q.pos_y = COORD_BITS'($urandom);
        q.pos_z = COORD_BITS'($urandom);
        q.radius = COORD_BITS'($urandom);
        q.is_static = 1'($urandom_range(0, 1));
        send_request(q);
    endtask

    task automatic load_body(input int x, input int y, input int z, input int r,
                             input bit s);
        req_t q;
        q.opcode = OP_LOAD;
        q.pos_x = x[COORD_BITS-1:0];
        q.pos_y = y[COORD_BITS-1:0];
        q.pos_z = z[COORD_BITS-1:0];
        q.radius = r[COORD_BITS-1:0];
        q.is_static = s;
        send_request(q);
    endtask

    // Near a cluster centre most of the time so boxes overlap; full range otherwise.
    function automatic int near_coord(int base);
        if ($urandom_range(0, 9) == 0)
            return $signed($urandom) >>> 8;
        return base + $signed($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int pick_radius();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0)
            return -$signed($urandom_range(1, 8388608));
        if (p == 1)
            return $urandom_range(0, 8388607);
        return $urandom_range(0, 1536);
    endfunction

    // One scene: clear, load a cluster, then sweep its pairs with a little noise mixed in.
    task automatic run_scene(input int n_load, input int n_fetch);
        int base_x;
        int base_y;
        int base_z;
        int p;
        base_x = $signed($urandom) >>> 9;
        base_y = $signed($urandom) >>> 9;
        base_z = $signed($urandom) >>> 9;
        send_op(OP_CLEAR);
        for (int i = 0; i < n_load; i++)
            load_body(near_coord(base_x), near_coord(base_y), near_coord(base_z),
                      pick_radius(), $urandom_range(0, 3) == 0);
        for (int i = 0; i < n_fetch; i++)
        begin
            p = $urandom_range(0, 39);
            if (p == 0)
                send_op(OP_NOP);
            else if (p == 1)
                send_op(OP_LOAD);     // restart the sweep mid-enumeration
            else if (p == 2)
                send_op(OP_CLEAR);
            else
                send_op(OP_FETCH);
        end
    endtask

    initial
    begin
        int n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty and single-body fetches, touching boxes, extremes, statics.
        send_op(OP_FETCH);
        load_body(0, 0, 0, 256, 1'b0);
        send_op(OP_FETCH);
        load_body(512, 512, -512, 256, 1'b0);     // touches the first box on every axis
        send_op(OP_FETCH);
        send_op(OP_FETCH);
        send_op(OP_FETCH);                        // stays exhausted
        load_body(8388607, 8388607, 8388607, 8388607, 1'b1);
        load_body(-8388608, -8388608, -8388608, -8388608, 1'b1);
        load_body(-8388608, -8388608, -8388608, 8388607, 1'b0);
        send_op(OP_FETCH);
        send_op(OP_FETCH);
        send_op(OP_FETCH);
        send_op(OP_NOP);
        send_op(OP_FETCH);
        send_op(OP_CLEAR);
        load_body(100, 100, 100, 500, 1'b1);
        load_body(100, 100, 100, 500, 1'b1);      // both static: skipped
        load_body(100, 100, 100, -1, 1'b0);       // negative radius, clamped to zero
        send_op(OP_FETCH);
        send_op(OP_FETCH);
        send_op(OP_FETCH);
        send_op(OP_FETCH);

        // Random scenes; the first fills the store, then sends further loads to overflow it.
        n = 0;
        while (sent < ITEM_TARGET)
        begin
            stall_on = $urandom_range(0, 4) != 0;
            if (n == 0 || $urandom_range(0, 29) == 0)
            begin
                run_scene(MAX_BODIES_DEF, 6);
                repeat ($urandom_range(1, 3)) send_op(OP_LOAD);
                send_op(OP_FETCH);
            end
            else
            begin
                run_scene($urandom_range(0, 12), $urandom_range(2, 24));
            end
            n++;
        end

        req_valid <= 1'b0;
        stall_on = 1'b1;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("ran %0d requests in %0d scenes: %0d pairs reported, %0d store-full loads",
                 sent, n, pair_count, full_count);
        if (fail_count == 0 && pending == 0)
            $display("sweep_prune_pair_finder: match");
        else
            $display("sweep_prune_pair_finder: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/spp_pkg.sv
rtl/spp_cell.sv
rtl/spp_ring.sv
rtl/sweep_prune_pair_finder.sv
sim/spp_pair_checker.sv
sim/tb_sweep_prune_pair_finder.sv
